// ----- sv/ftf_pkg.sv -----
// ----------------------------------------------------------------------------
// ftf_pkg
// Shared types and constants of the five-tuple filter: table sizing,
// configuration register indexes, verdict codes and protocol numbers.
// ----------------------------------------------------------------------------
package ftf_pkg;

    // Seen-hash table sizing
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Configuration port widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_SRC_ADDR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_PORT        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EITHER_ADDR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SRC_ADDR    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DST_ADDR    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EITHER_PORT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW         = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH        = 8'd7;

    // Register reset values
    localparam logic [31:0] RST_ALLOW_SRC_ADDR    = 32'd134744072;   // 8.8.8.8
    localparam logic [15:0] RST_ALLOW_PORT        = 16'd22;
    localparam logic [31:0] RST_BLOCK_EITHER_ADDR = 32'd3232235777;  // 192.168.1.1
    localparam logic [31:0] RST_BLOCK_SRC_ADDR    = 32'd167772165;   // 10.0.0.5
    localparam logic [31:0] RST_BLOCK_DST_ADDR    = 32'd2886729738;  // 172.16.0.10
    localparam logic [15:0] RST_BLOCK_EITHER_PORT = 16'd80;
    localparam logic [15:0] RST_RANGE_LOW         = 16'd1000;
    localparam logic [15:0] RST_RANGE_HIGH        = 16'd2000;

    // Protocol numbers and fixed blocked ports
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] PORT_HTTPS_SRC = 16'd443;
    localparam logic [15:0] PORT_FTP_DST   = 16'd21;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_DUP           = 3'd0,
        VERDICT_ALLOW         = 3'd1,
        VERDICT_IP_BLOCK      = 3'd2,
        VERDICT_PORT_BLOCK    = 3'd3,
        VERDICT_PROTO_BLOCK   = 3'd4,
        VERDICT_DEFAULT_ALLOW = 3'd5
    } verdict_t;

    // Number of hash steps, one field per step
    localparam int HASH_STEPS = 5;
    localparam int STEP_W     = $clog2(HASH_STEPS);

    // Reverse the byte order of an address (first wire byte least significant)
    function automatic logic [31:0] byte_reverse(input logic [31:0] a);
        byte_reverse = {a[7:0], a[15:8], a[23:16], a[31:24]};
    endfunction

endpackage

// ----- sv/five_tuple_filter_with_dedup.sv -----
// A request is hashed in 5 hash steps, the stored hashes are scanned until a
// match or the fill ends, and the finish state emits once the output is free.
// Throughput: one request at a time; s_ready is high only while the sequencer is
// idle, so the seen-table scan through its single read port sets the rate.
// Reset: aresetn (synchronous, active low) restores the register defaults and
// empties the seen table by clearing its fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
// five_tuple_filter_with_dedup
// Hashes the IPv4 five-tuple with a shared multiply-by-31 step, scans the
// seen-hash table for a duplicate and classifies new flows by rule order.
// ----------------------------------------------------------------------------
module five_tuple_filter_with_dedup
    import ftf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_src_addr,
    input  logic [31:0]           s_dst_addr,
    input  logic [7:0]            s_proto,
    input  logic [15:0]           s_raw_src_port,
    input  logic [15:0]           s_raw_dst_port,

    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_verdict,
    output logic [31:0]           m_flow_hash,
    output logic                  m_table_full,

    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [31:0] allow_src_addr_reg;
    logic [15:0] allow_port_reg;
    logic [31:0] block_either_addr_reg;
    logic [31:0] block_src_addr_reg;
    logic [31:0] block_dst_addr_reg;
    logic [15:0] block_either_port_reg;
    logic [15:0] range_low_reg;
    logic [15:0] range_high_reg;

    // Sequencer and captured request
    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  search_idx_reg;
    logic              cmp_pending_reg;
    logic              dup_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       src_reg;
    logic [31:0]       dst_reg;
    logic [7:0]        proto_reg;
    logic [15:0]       sp_reg;
    logic [15:0]       dp_reg;
    logic [31:0]       hash_reg;
    logic [31:0]       hash_next;
    logic [31:0]       hash_field;

    // Seen table
    logic [31:0]       mem [TABLE_DEPTH];
    logic [31:0]       rd_data_reg;
    logic              rd_en;
    logic              hit;
    logic              more;
    logic              table_has_room;
    logic              out_free;
    logic              wr_en;

    // Output registers
    logic              m_valid_reg;
    logic [2:0]        m_verdict_reg;
    logic [31:0]       m_flow_hash_reg;
    logic              m_table_full_reg;

    // Rule results
    verdict_t          rule_verdict;
    logic              allow_hit;
    logic              ip_hit;
    logic              port_hit;
    logic              proto_hit;
    logic              is_l4;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_flow_hash  = m_flow_hash_reg;
    assign m_table_full = m_table_full_reg;

    assign is_l4 = (s_proto == PROTO_TCP) || (s_proto == PROTO_UDP);

    // Shared hash unit: h * 31 + field, as (h << 5) - h + field
    always_comb begin
        unique case (step_reg)
            3'd0:    hash_field = byte_reverse(src_reg);
            3'd1:    hash_field = byte_reverse(dst_reg);
            3'd2:    hash_field = {24'd0, proto_reg};
            3'd3:    hash_field = {16'd0, sp_reg};
            3'd4:    hash_field = {16'd0, dp_reg};
            default: hash_field = 32'd0;
        endcase
        hash_next = (hash_reg << 5) - hash_reg + hash_field;
    end

    // Search control: compare the entry read last cycle, issue the next read
    assign hit            = cmp_pending_reg && (rd_data_reg == hash_reg);
    assign more           = (search_idx_reg < count_reg);
    assign rd_en          = (state_reg == ST_SEARCH) && !hit && more;
    assign table_has_room = (count_reg < CNT_W'(TABLE_DEPTH));
    assign out_free       = !m_valid_reg || m_ready;
    assign wr_en          = (state_reg == ST_FINISH) && out_free && !dup_reg
                            && table_has_room;

    // Rule checks in priority order
    always_comb begin
        allow_hit = (src_reg == allow_src_addr_reg) || (sp_reg == allow_port_reg)
                    || (dp_reg == allow_port_reg);
        ip_hit    = (src_reg == block_either_addr_reg) || (dst_reg == block_either_addr_reg)
                    || (src_reg == block_src_addr_reg) || (dst_reg == block_dst_addr_reg);
        port_hit  = (sp_reg == block_either_port_reg) || (dp_reg == block_either_port_reg)
                    || (sp_reg == PORT_HTTPS_SRC) || (dp_reg == PORT_FTP_DST)
                    || ((sp_reg >= range_low_reg) && (sp_reg <= range_high_reg))
                    || ((dp_reg >= range_low_reg) && (dp_reg <= range_high_reg));
        proto_hit = (proto_reg == PROTO_TCP) || (proto_reg == PROTO_UDP)
                    || (proto_reg == PROTO_ICMP);
        priority if (dup_reg) begin
            rule_verdict = VERDICT_DUP;
        end else if (allow_hit) begin
            rule_verdict = VERDICT_ALLOW;
        end else if (ip_hit) begin
            rule_verdict = VERDICT_IP_BLOCK;
        end else if (port_hit) begin
            rule_verdict = VERDICT_PORT_BLOCK;
        end else if (proto_hit) begin
            rule_verdict = VERDICT_PROTO_BLOCK;
        end else begin
            rule_verdict = VERDICT_DEFAULT_ALLOW;
        end
    end

    // Seen table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IDX_W-1:0]] <= hash_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[search_idx_reg[IDX_W-1:0]];
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_src_addr_reg    <= RST_ALLOW_SRC_ADDR;
            allow_port_reg        <= RST_ALLOW_PORT;
            block_either_addr_reg <= RST_BLOCK_EITHER_ADDR;
            block_src_addr_reg    <= RST_BLOCK_SRC_ADDR;
            block_dst_addr_reg    <= RST_BLOCK_DST_ADDR;
            block_either_port_reg <= RST_BLOCK_EITHER_PORT;
            range_low_reg         <= RST_RANGE_LOW;
            range_high_reg        <= RST_RANGE_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ALLOW_SRC_ADDR:    allow_src_addr_reg    <= cfg_data;
                REG_ALLOW_PORT:        allow_port_reg        <= cfg_data[15:0];
                REG_BLOCK_EITHER_ADDR: block_either_addr_reg <= cfg_data;
                REG_BLOCK_SRC_ADDR:    block_src_addr_reg    <= cfg_data;
                REG_BLOCK_DST_ADDR:    block_dst_addr_reg    <= cfg_data;
                REG_BLOCK_EITHER_PORT: block_either_port_reg <= cfg_data[15:0];
                REG_RANGE_LOW:         range_low_reg         <= cfg_data[15:0];
                REG_RANGE_HIGH:        range_high_reg        <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            search_idx_reg  <= '0;
            cmp_pending_reg <= 1'b0;
            dup_reg         <= 1'b0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Drop the result once taken; the finish state reloads it itself
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    // Capture the request; zero ports for non TCP/UDP
                    if (s_valid) begin
                        src_reg   <= s_src_addr;
                        dst_reg   <= s_dst_addr;
                        proto_reg <= s_proto;
                        sp_reg    <= is_l4 ? s_raw_src_port : 16'd0;
                        dp_reg    <= is_l4 ? s_raw_dst_port : 16'd0;
                        hash_reg  <= 32'd0;
                        step_reg  <= '0;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    // Advance one field per cycle through the shared unit
                    hash_reg <= hash_next;
                    if (step_reg == STEP_W'(HASH_STEPS - 1)) begin
                        search_idx_reg  <= '0;
                        cmp_pending_reg <= 1'b0;
                        dup_reg         <= 1'b0;
                        state_reg       <= ST_SEARCH;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SEARCH: begin
                    // Scan stored hashes one entry per cycle
                    if (hit) begin
                        dup_reg   <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else if (more) begin
                        search_idx_reg  <= search_idx_reg + 1'b1;
                        cmp_pending_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // Hold until the output register is free; emit, store a new hash if room
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_verdict_reg    <= rule_verdict;
                        m_flow_hash_reg  <= hash_reg;
                        m_table_full_reg <= !dup_reg && !table_has_room;
                        if (wr_en) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/ftf_checker.sv -----
// ----------------------------------------------------------------------------
// ftf_checker
// Port-level checks of the five-tuple filter, bound to the top level.
// ----------------------------------------------------------------------------
module ftf_checker
    import ftf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [2:0]            m_verdict,
    input logic [31:0]           m_flow_hash,
    input logic                  m_table_full
);

    // Hold a stalled result unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_flow_hash)
                                && $stable(m_table_full))
        else $error("result changed while stalled");

    // Take one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // A duplicate never reports a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_DUP) |-> !m_table_full)
        else $error("duplicate flagged table full");

    // Verdict codes stay in the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= VERDICT_DEFAULT_ALLOW))
        else $error("undefined verdict code");

endmodule

bind five_tuple_filter_with_dedup ftf_checker u_ftf_checker (.*);

// ----- test/five_tuple_filter_with_dedup_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_tuple_filter_with_dedup_tb
// Self-checking bench for the five-tuple filter. A directed table covers each
// rule, the port zeroing for non-TCP/UDP traffic and repeated flows. Random
// traffic then runs under several rule settings and idle patterns. Every
// result is checked against an in-bench flow classifier or a pinned verdict.
// ----------------------------------------------------------------------------
module five_tuple_filter_with_dedup_tb;
    import ftf_pkg::*;

    localparam int RULE_COUNT     = 8;
    localparam int REPEAT_PCT     = 15;
    localparam int HISTORY_DEPTH  = 64;
    localparam int REPORT_LIMIT   = 40;
    // Longest quiet stretch: a full-table scan plus short random stalls on either
    // side, taken several times over.
    localparam int WATCHDOG_LIMIT = 10 * (TABLE_DEPTH + 8);
    localparam int TAIL_CYCLES    = TABLE_DEPTH + 16;
    localparam int DIRECTED_ROWS  = 23;
    localparam logic [7:0] PROTO_ESP = 8'd50;

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
    } flow_request_t;

    typedef struct {
        verdict_t    verdict;
        logic [31:0] hash;
        logic        full;
    } flow_verdict_t;

    typedef struct {
        logic [31:0] allow_src;
        logic [31:0] allow_port;
        logic [31:0] block_either;
        logic [31:0] block_src;
        logic [31:0] block_dst;
        logic [31:0] block_port;
        logic [31:0] range_lo;
        logic [31:0] range_hi;
    } rule_set_t;

    // pinned rows carry a verdict that is obvious from the rules
    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        bit          pinned;
        verdict_t    verdict;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [31:0]           s_src_addr     = '0;
    logic [31:0]           s_dst_addr     = '0;
    logic [7:0]            s_proto        = '0;
    logic [15:0]           s_raw_src_port = '0;
    logic [15:0]           s_raw_dst_port = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [2:0]            m_verdict;
    logic [31:0]           m_flow_hash;
    logic                  m_table_full;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // classifier state
    rule_set_t     active_rules;
    bit            seen_flows [bit [31:0]];
    int            seen_total = 0;
    flow_verdict_t expected_verdicts [$];
    flow_request_t recent_flows [$];
    directed_row_t directed_rows [DIRECTED_ROWS];

    int send_idle_pct = 34;
    int recv_idle_pct = 55;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    five_tuple_filter_with_dedup uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_addr     (s_src_addr),
        .s_dst_addr     (s_dst_addr),
        .s_proto        (s_proto),
        .s_raw_src_port (s_raw_src_port),
        .s_raw_dst_port (s_raw_dst_port),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .m_flow_hash    (m_flow_hash),
        .m_table_full   (m_table_full),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Hash addresses with the first wire byte least significant
    function automatic bit [31:0] wire_order(input bit [31:0] a);
        bit [31:0] r;
        for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = a[31-8*k -: 8];
        end
        return r;
    endfunction

    function automatic bit port_in_range(input bit [15:0] p);
        return p >= active_rules.range_lo[15:0] && p <= active_rules.range_hi[15:0];
    endfunction

    // Classify one request and record its hash as the block would
    task automatic classify_flow(input flow_request_t req, output flow_verdict_t res);
        bit [31:0] h;
        bit [15:0] sp;
        bit [15:0] dp;
        bit        l4;
        l4 = (req.proto == PROTO_TCP) || (req.proto == PROTO_UDP);
        sp = l4 ? req.sport : 16'd0;
        dp = l4 ? req.dport : 16'd0;
        h = wire_order(req.src);
        h = h * 32'd31 + wire_order(req.dst);
        h = h * 32'd31 + {24'd0, req.proto};
        h = h * 32'd31 + {16'd0, sp};
        h = h * 32'd31 + {16'd0, dp};
        res.hash = h;
        res.full = 1'b0;
        if (seen_flows.exists(h)) begin
            res.verdict = VERDICT_DUP;
        end else begin
            if (req.src == active_rules.allow_src ||
                sp == active_rules.allow_port[15:0] ||
                dp == active_rules.allow_port[15:0]) begin
                res.verdict = VERDICT_ALLOW;
            end else if (req.src == active_rules.block_either ||
                         req.dst == active_rules.block_either ||
                         req.src == active_rules.block_src ||
                         req.dst == active_rules.block_dst) begin
                res.verdict = VERDICT_IP_BLOCK;
            end else if (sp == active_rules.block_port[15:0] ||
                         dp == active_rules.block_port[15:0] ||
                         sp == PORT_HTTPS_SRC || dp == PORT_FTP_DST ||
                         port_in_range(sp) || port_in_range(dp)) begin
                res.verdict = VERDICT_PORT_BLOCK;
            end else if (req.proto == PROTO_TCP || req.proto == PROTO_UDP ||
                         req.proto == PROTO_ICMP) begin
                res.verdict = VERDICT_PROTO_BLOCK;
            end else begin
                res.verdict = VERDICT_DEFAULT_ALLOW;
            end
            // store while there is room, else flag the overflow
            if (seen_total < TABLE_DEPTH) begin
                seen_flows[h] = 1'b1;
                seen_total++;
            end else begin
                res.full = 1'b1;
            end
        end
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return active_rules.allow_src;
            1: return active_rules.block_either;
            2: return active_rules.block_src;
            3: return active_rules.block_dst;
            4: return 32'h0000_0000;
            5: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 15))
            0: return active_rules.allow_port[15:0];
            1: return active_rules.block_port[15:0];
            2: return active_rules.range_lo[15:0];
            3: return active_rules.range_hi[15:0];
            4: return active_rules.range_lo[15:0] - 16'd1;
            5: return active_rules.range_hi[15:0] + 16'd1;
            6: return PORT_HTTPS_SRC;
            7: return PORT_FTP_DST;
            8: return 16'h0000;
            9: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 9))
            0, 1, 2: return PROTO_TCP;
            3, 4, 5: return PROTO_UDP;
            6: return PROTO_ICMP;
            7: return 8'h00;
            8: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly fresh flows aimed at the rules; some repeats of recent ones
    function automatic flow_request_t random_flow();
        flow_request_t req;
        if (recent_flows.size() != 0 && $urandom_range(0, 99) < REPEAT_PCT) begin
            req = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
            // ports are ignored off TCP/UDP: scramble them, still the same flow
            if (req.proto != PROTO_TCP && req.proto != PROTO_UDP &&
                $urandom_range(0, 1) == 1) begin
                req.sport = 16'($urandom);
                req.dport = 16'($urandom);
            end
            return req;
        end
        req.src   = pick_addr();
        req.dst   = pick_addr();
        req.proto = pick_proto();
        req.sport = pick_port();
        req.dport = pick_port();
        return req;
    endfunction

    function automatic rule_set_t random_rules(input bit empty_range);
        rule_set_t   s;
        logic [15:0] lo;
        logic [15:0] hi;
        s.allow_src    = $urandom;
        s.allow_port   = $urandom;
        s.block_either = $urandom;
        s.block_src    = $urandom;
        s.block_dst    = $urandom;
        s.block_port   = $urandom;
        if (empty_range) begin
            lo = 16'($urandom_range(1, 65535));
            hi = 16'($urandom_range(0, lo - 1));
        end else begin
            lo = 16'($urandom_range(0, 60000));
            hi = lo + 16'($urandom_range(0, 4000));
        end
        // junk in the upper half must be dropped by the 16-bit registers
        s.range_lo = {16'($urandom), lo};
        s.range_hi = {16'($urandom), hi};
        return s;
    endfunction

    // Write one register; hold cfg_valid for a following write
    task automatic write_rule(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ALLOW_SRC_ADDR:    active_rules.allow_src    = data;
            REG_ALLOW_PORT:        active_rules.allow_port   = {16'd0, data[15:0]};
            REG_BLOCK_EITHER_ADDR: active_rules.block_either = data;
            REG_BLOCK_SRC_ADDR:    active_rules.block_src    = data;
            REG_BLOCK_DST_ADDR:    active_rules.block_dst    = data;
            REG_BLOCK_EITHER_PORT: active_rules.block_port   = {16'd0, data[15:0]};
            REG_RANGE_LOW:         active_rules.range_lo     = {16'd0, data[15:0]};
            REG_RANGE_HIGH:        active_rules.range_hi     = {16'd0, data[15:0]};
            default: ;
        endcase
    endtask

    // Load a full rule set, plus one write to an unmapped index
    task automatic load_rules(input rule_set_t s);
        write_rule(REG_ALLOW_SRC_ADDR, s.allow_src);
        write_rule(REG_ALLOW_PORT, s.allow_port);
        write_rule(REG_BLOCK_EITHER_ADDR, s.block_either);
        write_rule(REG_BLOCK_SRC_ADDR, s.block_src);
        write_rule(REG_BLOCK_DST_ADDR, s.block_dst);
        write_rule(REG_BLOCK_EITHER_PORT, s.block_port);
        write_rule(REG_RANGE_LOW, s.range_lo);
        write_rule(REG_RANGE_HIGH, s.range_hi);
        write_rule(CFG_IDX_W'($urandom_range(RULE_COUNT, (1 << CFG_IDX_W) - 1)), $urandom);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one request; hold s_valid high afterwards for back-to-back traffic
    task automatic send_flow(input flow_request_t req, input bit pinned,
                             input verdict_t pinned_verdict);
        flow_verdict_t res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_src_addr     <= req.src;
        s_dst_addr     <= req.dst;
        s_proto        <= req.proto;
        s_raw_src_port <= req.sport;
        s_raw_dst_port <= req.dport;
        do @(posedge aclk); while (!s_ready);
        classify_flow(req, res);
        if (pinned) begin
            res.verdict = pinned_verdict;
        end
        expected_verdicts.push_back(res);
        recent_flows.push_back(req);
        if (recent_flows.size() > HISTORY_DEPTH) begin
            void'(recent_flows.pop_front());
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_flow(random_flow(), 1'b0, VERDICT_DUP);
    endtask

    // Drop valid and hold until every outstanding request has its result
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Result checker, ready pattern and watchdog
    always @(posedge aclk) begin : result_check
        flow_verdict_t exp;
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                note_mismatch($sformatf("unexpected result hash %08h", m_flow_hash));
            end else begin
                exp = expected_verdicts.pop_front();
                if (m_verdict !== exp.verdict) begin
                    note_mismatch($sformatf("verdict %0d, expected %0d (hash %08h)",
                                            m_verdict, exp.verdict, exp.hash));
                end
                if (m_flow_hash !== exp.hash) begin
                    note_mismatch($sformatf("flow_hash %08h, expected %08h",
                                            m_flow_hash, exp.hash));
                end
                if (m_table_full !== exp.full) begin
                    note_mismatch($sformatf("table_full %0b, expected %0b (hash %08h)",
                                            m_table_full, exp.full, exp.hash));
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        flow_request_t req;
        rule_set_t     s;

        active_rules = '{allow_src: RST_ALLOW_SRC_ADDR,
                         allow_port: {16'd0, RST_ALLOW_PORT},
                         block_either: RST_BLOCK_EITHER_ADDR,
                         block_src: RST_BLOCK_SRC_ADDR, block_dst: RST_BLOCK_DST_ADDR,
                         block_port: {16'd0, RST_BLOCK_EITHER_PORT},
                         range_lo: {16'd0, RST_RANGE_LOW},
                         range_hi: {16'd0, RST_RANGE_HIGH}};

        // src, dst, proto, sport, dport, pinned, verdict (reset rules)
        directed_rows = '{
            '{32'h0808_0808, 32'h0102_0304, PROTO_TCP, 16'd5000, 16'd80, 1'b1, VERDICT_ALLOW},
            '{32'h0101_0101, 32'h0202_0202, PROTO_UDP, 16'd22, 16'd3000, 1'b1, VERDICT_ALLOW},
            '{32'h0101_0101, 32'h0202_0202, PROTO_TCP, 16'd3000, 16'd22, 1'b1, VERDICT_ALLOW},
            '{32'hC0A8_0101, 32'h0202_0202, PROTO_ESP, 16'd0, 16'd0, 1'b1, VERDICT_IP_BLOCK},
            '{32'h0303_0303, 32'hC0A8_0101, PROTO_ESP, 16'd0, 16'd0, 1'b1, VERDICT_IP_BLOCK},
            '{32'h0A00_0005, 32'h0303_0303, 8'h00, 16'd0, 16'd0, 1'b1, VERDICT_IP_BLOCK},
            '{32'h0303_0303, 32'hAC10_000A, 8'hFF, 16'd0, 16'd0, 1'b1, VERDICT_IP_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, 16'd80, 16'd3000, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_UDP, 16'd3000, 16'd80, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, PORT_HTTPS_SRC, 16'd3000, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, 16'd3000, PORT_FTP_DST, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_UDP, 16'd1000, 16'd3000, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, 16'd3000, 16'd2000, 1'b1,
              VERDICT_PORT_BLOCK},
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, 16'd2001, 16'd999, 1'b1,
              VERDICT_PROTO_BLOCK},
            '{32'h0606_0606, 32'h0707_0707, PROTO_UDP, 16'hFFFF, 16'hFFFF, 1'b1,
              VERDICT_PROTO_BLOCK},
            // fixed ports only count for TCP/UDP
            '{32'h0909_0909, 32'h0A0A_0A0A, PROTO_ICMP, PORT_HTTPS_SRC, PORT_FTP_DST, 1'b1,
              VERDICT_PROTO_BLOCK},
            '{32'h0000_0000, 32'h0000_0000, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1,
              VERDICT_DEFAULT_ALLOW},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'h1234, 16'h1234, 1'b1,
              VERDICT_DEFAULT_ALLOW},
            // repeat of the first row
            '{32'h0808_0808, 32'h0102_0304, PROTO_TCP, 16'd5000, 16'd80, 1'b1, VERDICT_DUP},
            // same flow as the all-zero row once ports are zeroed
            '{32'h0000_0000, 32'h0000_0000, 8'h00, 16'd1234, 16'd0, 1'b1, VERDICT_DUP},
            // 443 as destination and 21 as source are not blocked
            '{32'h0404_0404, 32'h0505_0505, PROTO_TCP, PORT_FTP_DST, PORT_HTTPS_SRC, 1'b1,
              VERDICT_PROTO_BLOCK},
            '{32'h0000_0000, 32'h0000_0000, PROTO_TCP, 16'd0, 16'd0, 1'b0, VERDICT_DUP},
            '{32'h0404_0404, 32'h0505_0505, PROTO_UDP, 16'd2001, 16'd999, 1'b0, VERDICT_DUP}
        };

        // hold reset, then release
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table under reset rules
        send_idle_pct = 34;
        recv_idle_pct = 55;
        foreach (directed_rows[i]) begin
            req.src   = directed_rows[i].src;
            req.dst   = directed_rows[i].dst;
            req.proto = directed_rows[i].proto;
            req.sport = directed_rows[i].sport;
            req.dport = directed_rows[i].dport;
            send_flow(req, directed_rows[i].pinned, directed_rows[i].verdict);
        end
        wait_for_results();

        // random rules; pause the sender midway until the pipe is empty
        load_rules(random_rules(1'b0));
        send_random(75);
        wait_for_results();
        send_random(75);
        wait_for_results();

        // all-zero rules
        s = '{default: 32'h0};
        load_rules(s);
        send_random(100);
        wait_for_results();

        // swap the idle pattern; all-ones rules
        send_idle_pct = 55;
        recv_idle_pct = 34;
        s = '{default: 32'hFFFF_FFFF};
        load_rules(s);
        send_random(100);
        wait_for_results();

        // inverted bounds leave the port range empty
        load_rules(random_rules(1'b1));
        send_random(120);
        wait_for_results();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_rules(random_rules(1'b0));
        send_random(110);
        wait_for_results();

        // catch any stray results
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_verdicts.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
